// ----- design/bbcm_pkg.sv -----
// Shared constants and types for the block buffer cache manager.
`default_nettype none
package bbcm_pkg;
	localparam int ENTRIES = 64;
	localparam int SLOT_W  = $clog2(ENTRIES);
	localparam int LINK_W  = SLOT_W + 1;
	localparam logic [LINK_W-1:0] NIL = LINK_W'(ENTRIES);
	localparam logic [15:0] COUNT_MAX = 16'hFFFF;

	localparam logic CMD_GET     = 1'b0;
	localparam logic CMD_RELEASE = 1'b1;

	localparam logic [1:0] KIND_MAPPED = 2'd0;
	localparam logic [1:0] KIND_HOLE   = 2'd1;

	typedef enum logic [2:0] {
		ST_HIT       = 3'd0,
		ST_MISS      = 3'd1,
		ST_HOLE      = 3'd2,
		ST_UNMAPPED  = 3'd3,
		ST_EXHAUSTED = 3'd4,
		ST_FREED     = 3'd5,
		ST_HELD      = 3'd6,
		ST_BAD       = 3'd7
	} status_t;

	typedef struct packed {
		logic              hit;
		logic [SLOT_W-1:0] slot;
	} match_t;
endpackage
`default_nettype wire

// ----- design/bbcm_match.sv -----
// Parallel tag compare over all entries with a one-hot to index encode.
`default_nettype none
module bbcm_match (
	input  wire logic [31:0]       inode_number,
	input  wire logic [31:0]       file_block,
	input  wire logic              ent_valid [bbcm_pkg::ENTRIES],
	input  wire logic [31:0]       ent_inode [bbcm_pkg::ENTRIES],
	input  wire logic [31:0]       ent_index [bbcm_pkg::ENTRIES],
	output bbcm_pkg::match_t       result
);
	import bbcm_pkg::*;

	always_comb begin
		result = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			if (ent_valid[i] && ent_inode[i] == inode_number && ent_index[i] == file_block) begin
				result.hit  = 1'b1;
				result.slot = result.slot | SLOT_W'(i);
			end
		end
	end
endmodule
`default_nettype wire

// ----- design/block_buffer_cache_manager.sv -----
// Block buffer cache manager: tag store, reference counts and LRU idle list.
// An accepted request loads the input register and its result the result
// register. Throughput: one
// request per cycle, set by the single-pass tag compare and idle list update
// between the two registers; a held result stalls the input.
// Reset: all entries invalid, counts zero, idle list empty, no slot handed out.
`default_nettype none
module block_buffer_cache_manager (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic                         command,
	input  wire logic [31:0]                  inode_number,
	input  wire logic [31:0]                  file_block,
	input  wire logic [31:0]                  translated_address,
	input  wire logic [1:0]                   address_kind,
	input  wire logic [5:0]                   release_slot,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic [2:0]                        status,
	output logic [5:0]                        slot,
	output logic                              need_fill,
	output logic [31:0]                       fill_address,
	output logic                              evicted,
	output logic [15:0]                       reference_count
);
	import bbcm_pkg::*;

	logic              v_s1;
	logic              cmd_s1;
	logic [31:0]       ino_s1, idx_s1, taddr_s1;
	logic [1:0]        kind_s1;
	logic [5:0]        rslot_s1;

	logic              ent_valid_q [ENTRIES];
	logic [31:0]       ent_inode_q [ENTRIES];
	logic [31:0]       ent_index_q [ENTRIES];
	logic [31:0]       ent_addr_q  [ENTRIES];
	logic [15:0]       ent_cnt_q   [ENTRIES];
	logic [LINK_W-1:0] next_q      [ENTRIES];
	logic [LINK_W-1:0] prev_q      [ENTRIES];
	logic [LINK_W-1:0] head_q, tail_q, fresh_q;

	match_t            m;
	logic              adv;

	status_t           st;
	logic [SLOT_W-1:0] tgt;
	logic [15:0]       new_cnt;
	logic [31:0]       res_addr;
	logic              res_fill, res_evict;
	logic              cnt_we, alloc_we, fresh_inc;
	logic              unlink_en, push_en;
	logic [LINK_W-1:0] up, un;

	bbcm_match u_match (
		.inode_number (ino_s1),
		.file_block   (idx_s1),
		.ent_valid    (ent_valid_q),
		.ent_inode    (ent_inode_q),
		.ent_index    (ent_index_q),
		.result       (m)
	);

	assign adv      = v_s1 && (!out_valid || out_ready);
	assign in_ready = !v_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_s1   <= command;
			ino_s1   <= inode_number;
			idx_s1   <= file_block;
			taddr_s1 <= translated_address;
			kind_s1  <= address_kind;
			rslot_s1 <= release_slot;
		end
	end

	always_comb begin
		st        = ST_EXHAUSTED;
		tgt       = '0;
		new_cnt   = '0;
		res_addr  = '0;
		res_fill  = 1'b0;
		res_evict = 1'b0;
		cnt_we    = 1'b0;
		alloc_we  = 1'b0;
		fresh_inc = 1'b0;
		unlink_en = 1'b0;
		push_en   = 1'b0;
		if (cmd_s1 == CMD_RELEASE) begin
			tgt = SLOT_W'(rslot_s1);
			if (!ent_valid_q[tgt] || ent_cnt_q[tgt] == '0) begin
				st = ST_BAD;
			end else begin
				new_cnt  = ent_cnt_q[tgt] - 16'd1;
				res_addr = ent_addr_q[tgt];
				cnt_we   = 1'b1;
				if (new_cnt == '0) begin
					st      = ST_FREED;
					push_en = 1'b1;
				end else begin
					st = ST_HELD;
				end
			end
		end else if (m.hit) begin
			st        = ST_HIT;
			tgt       = m.slot;
			res_addr  = ent_addr_q[tgt];
			cnt_we    = 1'b1;
			unlink_en = (ent_cnt_q[tgt] == '0);
			new_cnt   = (ent_cnt_q[tgt] == COUNT_MAX) ? COUNT_MAX : ent_cnt_q[tgt] + 16'd1;
		end else if (kind_s1 == KIND_HOLE) begin
			st = ST_HOLE;
		end else if (kind_s1 != KIND_MAPPED) begin
			st = ST_UNMAPPED;
		end else if (fresh_q < NIL) begin
			st        = ST_MISS;
			tgt       = fresh_q[SLOT_W-1:0];
			fresh_inc = 1'b1;
		end else if (tail_q != NIL) begin
			st        = ST_MISS;
			tgt       = tail_q[SLOT_W-1:0];
			unlink_en = 1'b1;
			res_evict = 1'b1;
		end
		if (st == ST_MISS) begin
			alloc_we = 1'b1;
			cnt_we   = 1'b1;
			new_cnt  = 16'd1;
			res_fill = 1'b1;
			res_addr = taddr_s1;
		end
	end

	assign up = prev_q[tgt];
	assign un = next_q[tgt];

	// Tag payload and idle links: no reset, only read once written.
	always_ff @(posedge clk) begin
		if (adv) begin
			if (alloc_we) begin
				ent_inode_q[tgt] <= ino_s1;
				ent_index_q[tgt] <= idx_s1;
				ent_addr_q[tgt]  <= taddr_s1;
			end
			if (unlink_en) begin
				if (up != NIL) next_q[up[SLOT_W-1:0]] <= un;
				if (un != NIL) prev_q[un[SLOT_W-1:0]] <= up;
				prev_q[tgt] <= NIL;
				next_q[tgt] <= NIL;
			end
			if (push_en) begin
				prev_q[tgt] <= NIL;
				next_q[tgt] <= head_q;
				if (head_q != NIL) prev_q[head_q[SLOT_W-1:0]] <= LINK_W'(tgt);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ENTRIES; i++) begin
				ent_valid_q[i] <= 1'b0;
				ent_cnt_q[i]   <= '0;
			end
			head_q  <= NIL;
			tail_q  <= NIL;
			fresh_q <= '0;
		end else if (adv) begin
			if (alloc_we)  ent_valid_q[tgt] <= 1'b1;
			if (cnt_we)    ent_cnt_q[tgt]   <= new_cnt;
			if (fresh_inc) fresh_q <= fresh_q + LINK_W'(1);
			if (unlink_en) begin
				if (up == NIL) head_q <= un;
				if (un == NIL) tail_q <= up;
			end
			if (push_en) begin
				if (head_q == NIL) tail_q <= LINK_W'(tgt);
				head_q <= LINK_W'(tgt);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			status          <= st;
			slot            <= 6'(tgt);
			need_fill       <= res_fill;
			fill_address    <= res_addr;
			evicted         <= res_evict;
			reference_count <= new_cnt;
		end
	end
endmodule
`default_nettype wire
